/* hw/rtl/bounded_deque_with_search_defines.svh */
// Assertion macros for the bounded deque block.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define BDQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BDQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `BDQ_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

/* hw/rtl/bdq_pkg.sv */
// Shared constants, codes and types of the bounded deque block.
// No dependencies; used by the interfaces, bdq_store and the top level.
package bdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FUNC_W        = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_W       = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_POP_FRONT  = 3'd1,
    FUNC_PUSH_BACK  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_SEARCH     = 3'd4,
    FUNC_COUNT      = 3'd5,
    FUNC_CLEAR      = 3'd6
  } bdq_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } bdq_status_e;

  typedef struct packed {
    logic done;
    logic found;
  } bdq_scan_rsp_t;

  typedef struct packed {
    bdq_status_e        status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } bdq_result_t;

endpackage

/* hw/rtl/bdq_req_if.sv */
// Request channel of the bounded deque: valid/ready plus func and value.
// Depends on bdq_pkg for field widths.
interface bdq_req_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::FUNC_W-1:0]        func;
  logic signed [bdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

/* hw/rtl/bdq_rsp_if.sv */
// Response channel of the bounded deque: valid/ready plus status, found and count.
// Depends on bdq_pkg for field widths.
interface bdq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bdq_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [bdq_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output found, output count, input ready);
  modport sink (input valid, input status, input found, input count, output ready);
endinterface

/* hw/rtl/bdq_store.sv */
// Entry memory of the bounded deque and the sequential search engine over it.
// One registered read and one compare per cycle. Depends on bdq_pkg.
module bdq_store #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr_i,
  input  logic [bdq_pkg::DATA_W-1:0]  wr_data_i,
  input  logic                        scan_start_i,
  input  logic [$clog2(DEPTH)-1:0]    scan_base_i,
  input  logic [$clog2(DEPTH+1)-1:0]  scan_len_i,
  input  logic [bdq_pkg::DATA_W-1:0]  scan_key_i,
  output bdq_pkg::bdq_scan_rsp_t      scan_rsp_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [bdq_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [bdq_pkg::DATA_W-1:0] rd_data_q;
  logic [bdq_pkg::DATA_W-1:0] key_q;
  logic                       active_q;
  logic                       rd_vld_q;
  logic [IdxW-1:0]            addr_q;
  logic [CntW-1:0]            left_q;
  logic [IdxW-1:0]            addr_next;
  logic                       hit;
  logic                       issue;
  logic                       done;

  assign hit       = rd_vld_q && (rd_data_q == key_q);
  assign issue     = active_q && (left_q != '0) && !hit;
  assign done      = active_q && (hit || ((left_q == '0) && !rd_vld_q));
  assign addr_next = (addr_q == IdxW'(DEPTH - 1)) ? '0 : addr_q + 1'b1;

  assign scan_rsp_o.done  = done;
  assign scan_rsp_o.found = hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_data_q <= mem_q[addr_q];
    end
    if (scan_start_i) begin
      key_q <= scan_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rd_vld_q <= 1'b0;
      addr_q   <= '0;
      left_q   <= '0;
    end else if (scan_start_i) begin
      active_q <= 1'b1;
      rd_vld_q <= 1'b0;
      addr_q   <= scan_base_i;
      left_q   <= scan_len_i;
    end else if (active_q) begin
      rd_vld_q <= issue;
      if (issue) begin
        addr_q <= addr_next;
        left_q <= left_q - 1'b1;
      end
      if (done) begin
        active_q <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/bounded_deque_with_search.sv */
// Top level of the bounded deque with membership search.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_store and the assertion macro header.
//
// A ring of DEPTH signed 32-bit entries used as a double-ended list. Each request
// transfer gives exactly one response transfer carrying status, found and the count
// after the request. Push, pop, count and clear finish in the cycle of the request
// transfer, and the response is registered, or held pending while an earlier one
// waits. A search reads the held entries through the single read port of the entry
// memory, one entry and one compare per cycle, and stops at the first match. The
// request side is not ready during a search, nor while a finished result waits
// behind a response that has not yet been transferred.
// Entries need no clearing after reset, so the block is ready right away.
`include "bounded_deque_with_search_defines.svh"

module bounded_deque_with_search #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bdq_req_if.sink  req_i,
  bdq_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_WAIT = 3'b100
  } bdq_state_e;

  bdq_state_e              state_q, state_d;
  logic [IdxW-1:0]         front_q, front_d;
  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q;
  bdq_pkg::bdq_result_t    out_q;
  bdq_pkg::bdq_result_t    pend_q;
  bdq_pkg::bdq_result_t    res;
  bdq_pkg::bdq_scan_rsp_t  scan_rsp;

  logic                    req_fire;
  logic                    res_ready;
  logic                    out_free;
  logic                    is_full;
  logic                    is_empty;
  logic                    wr_en;
  logic [IdxW-1:0]         wr_addr;
  logic                    scan_start;
  logic [SumW-1:0]         back_sum;
  logic [SumW-1:0]         back_pos;
  logic [IdxW-1:0]         front_dec;
  logic [IdxW-1:0]         front_inc;
  logic [CntW+bdq_pkg::COUNT_W-1:0] cnt_ext;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign is_full   = (count_q == CntW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign back_sum  = SumW'(front_q) + SumW'(count_q);
  assign back_pos  = (back_sum >= SumW'(DEPTH)) ? back_sum - SumW'(DEPTH) : back_sum;
  assign front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign cnt_ext   = {{bdq_pkg::COUNT_W{1'b0}}, count_d};

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    wr_en      = 1'b0;
    wr_addr    = front_dec;
    scan_start = 1'b0;
    res.status = bdq_pkg::STATUS_OK;
    res.found  = 1'b0;
    res_ready  = 1'b0;
    if (req_fire) begin
      res_ready = 1'b1;
      case (bdq_pkg::bdq_func_e'(req_i.func))
        bdq_pkg::FUNC_PUSH_FRONT: begin
          if (is_full) begin
            res.status = bdq_pkg::STATUS_FULL;
          end else begin
            front_d = front_dec;
            wr_en   = 1'b1;
            wr_addr = front_dec;
            count_d = count_q + 1'b1;
          end
        end
        bdq_pkg::FUNC_POP_FRONT: begin
          if (is_empty) begin
            res.status = bdq_pkg::STATUS_EMPTY;
          end else begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
          end
        end
        bdq_pkg::FUNC_PUSH_BACK: begin
          if (is_full) begin
            res.status = bdq_pkg::STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = back_pos[IdxW-1:0];
            count_d = count_q + 1'b1;
          end
        end
        bdq_pkg::FUNC_POP_BACK: begin
          if (is_empty) begin
            res.status = bdq_pkg::STATUS_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        bdq_pkg::FUNC_SEARCH: begin
          scan_start = 1'b1;
          res_ready  = 1'b0;
        end
        bdq_pkg::FUNC_COUNT: begin
        end
        bdq_pkg::FUNC_CLEAR: begin
          front_d = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end else if (scan_rsp.done) begin
      res_ready = 1'b1;
      res.found = scan_rsp.found;
    end
    res.count = cnt_ext[bdq_pkg::COUNT_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (scan_start) begin
            state_d = ST_SCAN;
          end else if (!out_free) begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_d = out_free ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      if (state_q == ST_WAIT) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end
      end else if (res_ready && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT) begin
      if (out_free) begin
        out_q <= pend_q;
      end
    end else if (res_ready) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        pend_q <= res;
      end
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_q.status;
  assign rsp_o.found  = out_q.found;
  assign rsp_o.count  = out_q.count;

  bdq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_data_i    (req_i.value),
    .scan_start_i (scan_start),
    .scan_base_i  (front_q),
    .scan_len_i   (count_q),
    .scan_key_i   (req_i.value),
    .scan_rsp_o   (scan_rsp)
  );

  `BDQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(DEPTH), "count above depth")
  `BDQ_ASSERT(a_front_bound, clk_i, rst_ni, front_q <= IdxW'(DEPTH - 1), "front out of ring")
  `BDQ_ASSERT_NEVER(a_scan_done_idle, clk_i, rst_ni, scan_rsp.done && (state_q != ST_SCAN), "search result outside search")
  `BDQ_ASSERT(a_wait_holds_out, clk_i, rst_ni, (state_q == ST_WAIT) |-> out_valid_q, "pending result without busy output")
  `BDQ_ASSERT(a_full_push_keeps, clk_i, rst_ni, (req_fire && is_full && (req_i.func == bdq_pkg::FUNC_PUSH_FRONT || req_i.func == bdq_pkg::FUNC_PUSH_BACK)) |=> (count_q == $past(count_q)), "refused push changed count")

endmodule

/* test/bounded_deque_with_search_test.sv */
// Self-checking testbench for bounded_deque_with_search: queued requests, bursty driver,
// stalling response sink, and a checker that predicts every response in order.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module bounded_deque_with_search_test;
  import bdq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEFAULT;
  localparam int unsigned RAND_ITEMS = 450;
  localparam int unsigned CYCLE_MAX  = 200000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } deque_req_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY, MIX_SCAN} mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_with_search #(.DEPTH(DEPTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  deque_req_t               request_queue[$];
  bdq_result_t              pending_results[$];
  logic signed [DATA_W-1:0] pushed_values[$];

  logic signed [DATA_W-1:0] ring_model[DEPTH];
  int unsigned              front_model;
  int unsigned              count_model;

  int          error_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned open_left;
  bdq_result_t want;
  bdq_result_t got;

  task automatic apply_request(input logic [FUNC_W-1:0] func,
                               input logic signed [DATA_W-1:0] value,
                               output bdq_result_t res);
    res.status = STATUS_OK;
    res.found  = 1'b0;
    case (func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (count_model >= DEPTH) begin
          res.status = STATUS_FULL;
        end else if (func == FUNC_PUSH_FRONT) begin
          front_model = (front_model + DEPTH - 1) % DEPTH;
          ring_model[front_model] = value;
          count_model++;
        end else begin
          ring_model[(front_model + count_model) % DEPTH] = value;
          count_model++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (count_model == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          if (func == FUNC_POP_FRONT) front_model = (front_model + 1) % DEPTH;
          count_model--;
        end
      end
      FUNC_SEARCH: begin
        for (int unsigned i = 0; i < count_model; i++) begin
          if (ring_model[(front_model + i) % DEPTH] == value) res.found = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        count_model = 0;
        front_model = 0;
      end
      default: ;
    endcase
    res.count = count_model[COUNT_W-1:0];
  endtask

  task automatic add_req(input logic [FUNC_W-1:0] func, input logic signed [DATA_W-1:0] value);
    deque_req_t r;
    r.func  = func;
    r.value = value;
    request_queue.push_back(r);
    if (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_BACK) begin
      pushed_values.push_back(value);
      if (pushed_values.size() > 24) void'(pushed_values.pop_front());
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4, 5: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_search_value();
    if (pushed_values.size() != 0 && $urandom_range(0, 2) != 0)
      return pushed_values[$urandom_range(0, pushed_values.size() - 1)];
    return pick_value();
  endfunction

  task automatic build_random(input int unsigned n);
    mix_e        mix;
    int unsigned mix_left;
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned search_pct;
    mix_left = 0;
    mix = MIX_FILL;
    for (int unsigned k = 0; k < n; k++) begin
      if (mix_left == 0) begin
        mix = mix_e'($urandom_range(0, 3));
        mix_left = $urandom_range(8, 40);
      end
      mix_left--;
      case (mix)
        MIX_FILL:  begin push_pct = 75; pop_pct = 10; search_pct = 12; end
        MIX_DRAIN: begin push_pct = 10; pop_pct = 75; search_pct = 12; end
        MIX_SCAN:  begin push_pct = 25; pop_pct = 20; search_pct = 50; end
        default:   begin push_pct = 35; pop_pct = 35; search_pct = 20; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        add_req($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, pick_value());
      end else if (roll < push_pct + pop_pct) begin
        add_req($urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK, $urandom);
      end else if (roll < push_pct + pop_pct + search_pct) begin
        add_req(FUNC_SEARCH, pick_search_value());
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 6) add_req(FUNC_COUNT, $urandom);
        else if (roll < 8) add_req(FUNC_UNUSED, $urandom);
        else add_req(FUNC_CLEAR, $urandom);
      end
    end
  endtask

  // driver: present the head of the request queue in bursts, hold it until transfer
  always @(posedge clk_i) begin
    if (rst_ni && !(req_if.valid && !req_if.ready)) begin
      if (req_if.valid) void'(request_queue.pop_front());
      if (gap_left != 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (request_queue.size() == 0) begin
        req_if.valid <= 1'b0;
      end else begin
        req_if.valid <= 1'b1;
        req_if.func  <= request_queue[0].func;
        req_if.value <= request_queue[0].value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // response sink: open windows of random length separated by short stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (open_left != 0) begin
        open_left--;
        rsp_if.ready <= 1'b1;
      end else begin
        open_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
        stall_left = $urandom_range(1, 7);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor: check each response transfer, then predict from each request transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = bdq_status_e'(rsp_if.status);
        got.found  = rsp_if.found;
        got.count  = rsp_if.count;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected response status %0d found %0d count %0d",
                   $time, got.status, got.found, got.count);
          error_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
            error_cnt++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_if.found);
            error_cnt++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_if.count);
            error_cnt++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        apply_request(req_if.func, req_if.value, want);
        pending_results.push_back(want);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_MAX) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[bounded_deque_with_search] ERROR");
    $finish;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.func  = FUNC_COUNT;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    error_cnt   = 0;
    front_model = 0;
    count_model = 0;
    burst_left  = 0;
    gap_left    = 0;
    stall_left  = 0;
    open_left   = 0;
    foreach (ring_model[i]) ring_model[i] = '0;

    add_req(FUNC_POP_FRONT, $urandom);
    add_req(FUNC_POP_BACK, $urandom);
    add_req(FUNC_PUSH_BACK, 5);
    add_req(FUNC_POP_BACK, $urandom);
    add_req(FUNC_PUSH_FRONT, 32'h7fff_ffff);
    add_req(FUNC_PUSH_BACK, 32'h8000_0000);
    add_req(FUNC_SEARCH, 32'h8000_0000);
    for (int i = 0; i < DEPTH - 2; i++) begin
      add_req((i % 2) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, -(i + 2));
    end
    add_req(FUNC_PUSH_FRONT, 777);
    add_req(FUNC_SEARCH, 777);
    add_req(FUNC_SEARCH, 32'h7fff_ffff);
    add_req(FUNC_COUNT, '1);
    add_req(FUNC_UNUSED, '1);
    add_req(FUNC_CLEAR, $urandom);
    add_req(FUNC_POP_FRONT, $urandom);
    build_random(RAND_ITEMS);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || pending_results.size() != 0) @(negedge clk_i);
    repeat (DEPTH + 8) @(negedge clk_i);

    if (error_cnt == 0) begin
      $display("[bounded_deque_with_search] OK");
    end else begin
      $display("[bounded_deque_with_search] ERROR");
    end
    $finish;
  end

endmodule
